[sv/angle_gyro_bias_kalman_macros.svh]
// Assertion helpers shared by the filter's RTL.
`ifndef ANGLE_GYRO_BIAS_KALMAN_MACROS_SVH
`define ANGLE_GYRO_BIAS_KALMAN_MACROS_SVH

// Assert that prop holds at every clock edge outside reset.
`define AGBK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert prop with reset included.
`define AGBK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/agbk_pkg.sv]
`default_nettype none
package agbk_pkg;

  typedef struct packed {
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_rate;
  } agbk_in_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] rate_unbiased;
  } agbk_out_t;

  localparam logic [1:0] REG_STEP_TIME     = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

  // Datapath micro-operations issued by the sequencer.
  typedef enum logic [4:0] {
    OP_NOP     = 5'd0,
    OP_LOAD    = 5'd1,   // capture input beat
    OP_RATE    = 5'd2,   // r = sat(gyro - bias)
    OP_MDT_R   = 5'd3,   // product = r * dt
    OP_ANG_P   = 5'd4,   // angle += rnd(product)
    OP_ERR     = 5'd5,   // err, pd0, pd1
    OP_MDT_P0  = 5'd6,
    OP_C00_P   = 5'd7,
    OP_MDT_P1  = 5'd8,
    OP_C01_P   = 5'd9,   // also cov_10
    OP_MDT_BN  = 5'd10,
    OP_C11_P   = 5'd11,
    OP_EVAR    = 5'd12,  // e, start divide k0
    OP_DIV0    = 5'd13,  // capture k0, start divide k1
    OP_DIV1    = 5'd14,  // capture k1
    OP_MQ_00   = 5'd15,  // k0*t0
    OP_U00     = 5'd16,
    OP_MQ_01   = 5'd17,
    OP_U01     = 5'd18,
    OP_MQ_10   = 5'd19,
    OP_U10     = 5'd20,
    OP_MQ_11   = 5'd21,
    OP_U11     = 5'd22,
    OP_MQ_A    = 5'd23,
    OP_UA      = 5'd24,
    OP_MQ_B    = 5'd25,
    OP_UB      = 5'd26,
    OP_OUT     = 5'd27
  } agbk_op_t;

  typedef struct packed {
    agbk_op_t op;
  } agbk_cmd_t;

  typedef struct packed {
    logic div_busy;
  } agbk_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > 35'sd2147483647) r = 32'sh7fffffff;
    else if (x < -35'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/angle_gyro_bias_kalman.sv]
`default_nettype none
// Two-state Kalman filter for tilt angle and gyro bias, signed fixed point.
// Input channel in_*: one beat carries accel_angle and gyro_rate; it is taken
// when in_valid and in_ready are both high. in_ready is high only while the
// block is idle, so one sample is in flight at a time.
// Output channel out_*: one beat per sample, angle_estimate and the gyro rate
// minus the updated bias, held in out_data until out_valid and out_ready meet.
// Ten of the 26 ops after the load share one multiplier; two gain divisions
// each hold the sequencer in a wait state on the one radix-2 divider. The next
// beat is accepted once the result moves into the output register, so a new
// sample is not taken before the last one is done. While the receiver stalls,
// the next sample runs and holds its result until the output register frees.
// Reset (rst_n low, synchronous): estimates clear, covariance diagonal = 1.0,
// registers return to defaults. cfg_* writes are registered; write only
// while idle. The two-bit cfg_index selects one of the four registers.
`include "angle_gyro_bias_kalman_macros.svh"
module angle_gyro_bias_kalman
  import agbk_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire agbk_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output agbk_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);
  localparam logic [30:0] NOISE_DEF = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [30:0] MEAS_DEF  = 31'((64'd1 << FRAC_BITS) / 64'd2);

  logic [15:0] step_time_r;
  logic [30:0] angle_noise_r, bias_noise_r, measure_noise_r;
  agbk_cmd_t   cmd;
  agbk_sts_t   sts;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= 16'd328;
      angle_noise_r <= NOISE_DEF;
      bias_noise_r <= NOISE_DEF;
      measure_noise_r <= MEAS_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_TIME:     step_time_r <= cfg_data[15:0];
        REG_ANGLE_NOISE:   angle_noise_r <= cfg_data;
        REG_BIAS_NOISE:    bias_noise_r <= cfg_data;
        REG_MEASURE_NOISE: measure_noise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  agbk_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  agbk_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .step_time(step_time_r), .angle_noise(angle_noise_r), .bias_noise(bias_noise_r),
    .measure_noise(measure_noise_r), .res(out_data)
  );

  `AGBK_ASSERT(a_load_only_on_accept, (cmd.op == OP_LOAD) == (in_valid && in_ready), "load without accept")
  `AGBK_ASSERT(a_out_holds, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)), "result dropped")
  `AGBK_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "out_valid after reset")
endmodule
`default_nettype wire

[sv/agbk_div.sv]
`default_nettype none
// Restoring divider: quot = round(n * 2^F / d), ties away from zero, one bit a cycle.
module agbk_div
  import agbk_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    busy,
  output logic signed [31:0]      quot
);
  localparam int NW = 32 + FRAC_BITS;   // magnitude of num * 2^F
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] mag_r, mag_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [31:0]   d_r, d_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  logic [33:0] trial;
  logic [33:0] twice_rem;
  logic [NW:0] rounded;
  logic signed [NW+1:0] signed_q;
  logic [32:0] nmag;

  always_comb begin
    mag_nxt = mag_r; rem_nxt = rem_r; q_nxt = q_r; d_nxt = d_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    nmag = num[31] ? 33'(-{num[31], num}) : 33'({1'b0, num});
    trial = {rem_r, mag_r[NW-1]} - {2'b00, d_r};
    if (start) begin
      mag_nxt = NW'(nmag) << FRAC_BITS;
      rem_nxt = '0; q_nxt = '0; d_nxt = den;
      neg_nxt = num[31]; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = mag_r << 1;
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], mag_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  // Round: add one when rem >= ceil(d/2), i.e. 2*rem >= d + (d odd).
  always_comb begin
    twice_rem = {rem_r, 1'b0};
    rounded = {1'b0, q_r} + ((twice_rem >= ({2'b0, d_r} + {33'd0, d_r[0]})) ? 1'b1 : 1'b0);
    signed_q = neg_r ? -$signed({1'b0, rounded}) : $signed({1'b0, rounded});
    if (signed_q > (NW+2)'(64'sd2147483647)) quot = 32'sh7fffffff;
    else if (signed_q < -(NW+2)'(64'sd2147483648)) quot = 32'sh80000000;
    else quot = signed_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt; rem_r <= rem_nxt; q_r <= q_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

[sv/agbk_datapath.sv]
`default_nettype none
// Registers, one shared multiplier and the divider; executes one op per cycle while the sequencer is not waiting.
module agbk_datapath
  import agbk_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire agbk_cmd_t   cmd,
  output agbk_sts_t        sts,
  input  wire agbk_in_t    in_data,
  input  wire logic [15:0] step_time,
  input  wire logic [30:0] angle_noise,
  input  wire logic [30:0] bias_noise,
  input  wire logic [30:0] measure_noise,
  output agbk_out_t        res
);
  localparam int DT_BITS = 16;
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] angle_r, bias_r, c00_r, c01_r, c10_r, c11_r;
  logic signed [31:0] accel_r, gyro_r, tmp_r, err_r, pd0_r, pd1_r;
  logic signed [31:0] e_r, k0_r, k1_r, t0_r, t1_r;
  logic signed [63:0] prod_r;
  logic               dt_prod_r;
  agbk_out_t          res_r;

  logic signed [31:0] ma, mb;
  logic               m_dt;
  logic signed [63:0] mprod;
  logic signed [63:0] rnd;
  logic signed [31:0] prod_sat;
  logic               div_start, div_busy;
  logic signed [31:0] div_num, div_q;

  // Multiplier operand select.
  always_comb begin
    ma = '0; mb = '0; m_dt = 1'b0;
    case (cmd.op)
      OP_MDT_R:  begin ma = tmp_r; m_dt = 1'b1; end
      OP_MDT_P0: begin ma = pd0_r; m_dt = 1'b1; end
      OP_MDT_P1: begin ma = pd1_r; m_dt = 1'b1; end
      OP_MDT_BN: begin ma = {1'b0, bias_noise}; m_dt = 1'b1; end
      OP_MQ_00:  begin ma = k0_r; mb = t0_r; end
      OP_MQ_01:  begin ma = k0_r; mb = t1_r; end
      OP_MQ_10:  begin ma = k1_r; mb = t0_r; end
      OP_MQ_11:  begin ma = k1_r; mb = t1_r; end
      OP_MQ_A:   begin ma = k0_r; mb = err_r; end
      OP_MQ_B:   begin ma = k1_r; mb = err_r; end
      default:   ;
    endcase
    if (m_dt) mprod = ma * $signed({16'd0, step_time});
    else mprod = ma * mb;
  end

  // Round half up then floor shift, clamp.
  always_comb begin
    if (dt_prod_r) rnd = (prod_r + (64'sd1 <<< (DT_BITS - 1))) >>> DT_BITS;
    else rnd = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (rnd > 64'sd2147483647) prod_sat = 32'sh7fffffff;
    else if (rnd < -64'sd2147483648) prod_sat = 32'sh80000000;
    else prod_sat = rnd[31:0];
  end

  always_comb begin
    div_start = (cmd.op == OP_EVAR) || (cmd.op == OP_DIV0);
    div_num = (cmd.op == OP_EVAR) ? c00_r : c10_r;
  end

  logic signed [31:0] e_now;
  assign e_now = sat32(35'(c00_r) + 35'($signed({1'b0, measure_noise})));

  agbk_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den((cmd.op == OP_EVAR) ? e_now : e_r), .busy(div_busy), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0; bias_r <= '0; c00_r <= ONE_Q; c01_r <= '0; c10_r <= '0; c11_r <= ONE_Q;
    end else begin
      case (cmd.op)
        OP_ANG_P: angle_r <= sat32(35'(angle_r) + 35'(prod_sat));
        OP_C00_P: c00_r <= sat32(35'(c00_r) + 35'(prod_sat));
        OP_C01_P: begin
          c01_r <= sat32(35'(c01_r) + 35'(prod_sat));
          c10_r <= sat32(35'(c10_r) + 35'(prod_sat));
        end
        OP_C11_P: c11_r <= sat32(35'(c11_r) + 35'(prod_sat));
        OP_U00:   c00_r <= sat32(35'(c00_r) - 35'(prod_sat));
        OP_U01:   c01_r <= sat32(35'(c01_r) - 35'(prod_sat));
        OP_U10:   c10_r <= sat32(35'(c10_r) - 35'(prod_sat));
        OP_U11:   c11_r <= sat32(35'(c11_r) - 35'(prod_sat));
        OP_UA:    angle_r <= sat32(35'(angle_r) + 35'(prod_sat));
        OP_UB:    bias_r <= sat32(35'(bias_r) + 35'(prod_sat));
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mprod;
    dt_prod_r <= m_dt;
    case (cmd.op)
      OP_LOAD: begin accel_r <= in_data.accel_angle; gyro_r <= in_data.gyro_rate; end
      OP_RATE: tmp_r <= sat32(35'(gyro_r) - 35'(bias_r));
      OP_ERR: begin
        err_r <= sat32(35'(accel_r) - 35'(angle_r));
        pd0_r <= sat32(35'($signed({1'b0, angle_noise})) - 35'(c01_r) - 35'(c10_r));
        pd1_r <= sat32(-35'(c11_r));
      end
      OP_EVAR: e_r <= e_now;
      OP_DIV0: k0_r <= (e_r > 0) ? div_q : '0;
      OP_DIV1: begin
        k1_r <= (e_r > 0) ? div_q : '0;
        t0_r <= c00_r; t1_r <= c01_r;
      end
      OP_OUT: begin
        res_r.angle_estimate <= angle_r;
        res_r.rate_unbiased <= sat32(35'(gyro_r) - 35'(bias_r));
      end
      default: ;
    endcase
  end

  assign sts.div_busy = div_busy;
  assign res = res_r;
endmodule
`default_nettype wire

[sv/agbk_ctrl.sv]
`default_nettype none
// Sequencer: walks the op list, waits on the divider, hands out one result.
module agbk_ctrl
  import agbk_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output agbk_cmd_t      cmd,
  input  wire agbk_sts_t sts
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t   state_r, state_nxt;
  agbk_op_t op_r, op_nxt;
  logic     ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; ov_nxt = ov_r;
    cmd.op = OP_NOP;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          op_nxt = OP_RATE;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (op_r == OP_OUT) begin
          // Load the output register only once it is free.
          state_nxt = ST_DONE;
          if (!ov_r || out_ready) begin
            cmd.op = OP_OUT;
            ov_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.op = op_r;
          if (op_r == OP_EVAR || op_r == OP_DIV0) state_nxt = ST_WAIT;
          op_nxt = agbk_op_t'(op_r + 5'd1);
        end
      end
      ST_WAIT: begin
        // Hold until divider finishes (start registers busy, so it is already high here).
        if (!sts.div_busy) state_nxt = ST_RUN;
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.op = OP_OUT;
          ov_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r <= OP_NOP;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire
